@@ rtl/sbvrd_pkg.sv @@
`timescale 1ns / 1ps

package sbvrd_pkg;

   // Request codes.
   localparam logic [7:0] ReqVersion = 8'h5F;
   localparam logic [7:0] ReqRead    = 8'h95;
   localparam logic [7:0] ReqWrite   = 8'h9A;
   localparam logic [7:0] ReqInit    = 8'hA1;
   localparam logic [7:0] ReqModem   = 8'hA4;

   // Register addresses and write commands.
   localparam logic [15:0] RegAttach = 16'h1825;
   localparam logic [15:0] RegStatus = 16'h0607;
   localparam logic [15:0] CmdBaud   = 16'h1213;
   localparam logic [15:0] CmdMode   = 16'h1825;

   // Configuration register indexes.
   localparam logic [1:0] CsrVersion = 2'd0;
   localparam logic [1:0] CsrAttach  = 2'd1;
   localparam logic [1:0] CsrStatus  = 2'd2;

   localparam logic [15:0] VersionReset = 16'h0030;
   localparam logic [15:0] AttachReset  = 16'h00C3;
   localparam logic [15:0] StatusReset  = 16'hEEFF;

   // Baud arithmetic. The denominator is (256 - factor) << (8 + 3*(3 - divisor)),
   // so the power of two is taken off the numerator first and only a
   // 9-bit divisor remains.
   localparam logic [30:0] BaudNumerator = 31'd1532620800;
   localparam int          QuoWidth      = 23;
   localparam int          RemWidth      = 9;
   localparam logic [7:0]  DivLimit      = 8'd3;
   localparam logic [4:0]  DivSteps      = 5'(QuoWidth);

   localparam logic [QuoWidth-1:0] Dividend0 = QuoWidth'(BaudNumerator >> 17);
   localparam logic [QuoWidth-1:0] Dividend1 = QuoWidth'(BaudNumerator >> 14);
   localparam logic [QuoWidth-1:0] Dividend2 = QuoWidth'(BaudNumerator >> 11);
   localparam logic [QuoWidth-1:0] Dividend3 = QuoWidth'(BaudNumerator >> 8);

   typedef struct packed {
      logic [7:0]  func;
      logic [15:0] value_word;
      logic [15:0] index_word;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [1:0]          response_length;
      logic [15:0]         response_word;
      logic                baud_valid;
      logic                baud_error;
      logic [QuoWidth-1:0] baud_rate;
      logic                mode_valid;
      logic [3:0]          data_bits;
      logic [1:0]          stop_bits;
      logic [1:0]          parity_kind;
      logic                parity_stick;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_status_type;

   typedef enum logic [1:0] {
      StIdle,
      StDivide,
      StRespond
   } state_type;

endpackage

@@ rtl/sbvrd_ctrl.sv @@
`timescale 1ns / 1ps

module sbvrd_ctrl
   import sbvrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   state_type  state_ff, state_in;
   logic [4:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         StIdle: begin
            // The input stays closed while reset is held.
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               count_in = DivSteps - 5'd1;
               state_in = dp_status.need_div ? StDivide : StRespond;
            end
         end
         StDivide: begin
            cmd.step = 1'b1;
            if (count_ff == '0) begin
               cmd.last = 1'b1;
               state_in = StRespond;
            end else begin
               count_in = count_ff - 5'd1;
            end
         end
         StRespond: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

endmodule

@@ rtl/sbvrd_dp.sv @@
`timescale 1ns / 1ps

module sbvrd_dp
   import sbvrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   output rsp_type       rsp_data,
   input  logic          csr_write,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   input  cmd_type       cmd,
   output dp_status_type dp_status
);

   logic [15:0] version_ff;
   logic [15:0] attach_ff;
   logic [15:0] status_word_ff;

   rsp_type             result_ff, result_in;
   logic [QuoWidth-1:0] quo_ff, quo_in;
   logic [RemWidth-1:0] rem_ff, rem_in;
   logic [RemWidth-1:0] dvs_ff, dvs_in;

   logic [7:0]          factor;
   logic [7:0]          divisor;
   logic [7:0]          mode;
   logic                is_baud;
   logic [QuoWidth-1:0] dividend;
   logic [RemWidth:0]   trial;
   logic                fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff     <= VersionReset;
         attach_ff      <= AttachReset;
         status_word_ff <= StatusReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrVersion: version_ff     <= csr_wdata;
            CsrAttach:  attach_ff      <= csr_wdata;
            CsrStatus:  status_word_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign factor  = req_data.index_word[15:8];
   assign divisor = req_data.index_word[7:0];
   assign mode    = req_data.index_word[7:0];
   assign is_baud = (req_data.func == ReqWrite) && (req_data.value_word == CmdBaud);

   assign dp_status.need_div = is_baud && (divisor <= DivLimit);

   // The shifted numerator depends only on the divisor code.
   always_comb begin
      unique case (divisor[1:0])
         2'd0:    dividend = Dividend0;
         2'd1:    dividend = Dividend1;
         2'd2:    dividend = Dividend2;
         default: dividend = Dividend3;
      endcase
   end

   assign trial = {rem_ff, quo_ff[QuoWidth-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      result_in = result_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (cmd.load) begin
         result_in = '0;
         result_in.status = 1'b1;
         unique case (req_data.func)
            ReqVersion: begin
               result_in.status          = 1'b0;
               result_in.response_length = 2'd2;
               result_in.response_word   = version_ff;
            end
            ReqRead: begin
               if (req_data.value_word == RegAttach) begin
                  result_in.status          = 1'b0;
                  result_in.response_length = 2'd2;
                  result_in.response_word   = attach_ff;
               end else if (req_data.value_word == RegStatus) begin
                  result_in.status          = 1'b0;
                  result_in.response_length = 2'd2;
                  result_in.response_word   = status_word_ff;
               end
            end
            ReqWrite: begin
               result_in.status = 1'b0;
               if (is_baud) begin
                  result_in.baud_valid = dp_status.need_div;
                  result_in.baud_error = !dp_status.need_div;
               end else if (req_data.value_word == CmdMode) begin
                  result_in.mode_valid = 1'b1;
                  result_in.data_bits  = {2'b00, mode[1:0]} + 4'd5;
                  result_in.stop_bits  = {1'b0, mode[2]} + 2'd1;
                  if (mode[3]) begin
                     result_in.parity_kind  = mode[4] ? 2'd2 : 2'd1;
                     result_in.parity_stick = mode[5];
                  end
               end
            end
            ReqInit, ReqModem: begin
               result_in.status = 1'b0;
            end
            default: ;
         endcase
         quo_in = dividend;
         rem_in = '0;
         dvs_in = 9'd256 - {1'b0, factor};
      end else if (cmd.step) begin
         // One restoring step: bring down the next dividend bit, subtract if it fits.
         rem_in = fits ? RemWidth'(trial - {1'b0, dvs_ff}) : trial[RemWidth-1:0];
         quo_in = {quo_ff[QuoWidth-2:0], fits};
         if (cmd.last) begin
            result_in.baud_rate = quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
   end

   assign rsp_data = result_ff;

endmodule

@@ rtl/serial_bridge_vendor_request_decoder.sv @@
`timescale 1ns / 1ps

// Vendor control request decoder for an emulated USB serial bridge.
// req_*: one request word (code, setup value, setup index) with valid/stall.
// rsp_*: one result word per request with valid/stall: status, an optional
//    two-byte data stage, and the baud or line mode that a register write sets.
// csr_*: register writes (version, attach, status words); csr_ready is always
//    high, and writes are expected only while no request is in flight.
// A result is presented in the cycle after its request is accepted, except a
//    set-baud write with a valid divisor, which first runs a 23-step restoring
//    divider (one quotient bit per cycle) and is presented once the divider has
//    finished. One request is in flight at a time, so the next request is not
//    accepted until the result of the last one has been taken.
// The result is held in an output register; while rsp_stall is high it
//    stays on rsp_data and req_stall stays high.
// Reset clears the controller and loads the register reset values; no
//    result is pending after reset, and req_stall is high while reset is held.

module serial_bridge_vendor_request_decoder
   import sbvrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type       cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   sbvrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   sbvrd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   // Only one request may be in flight.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.baud_valid && rsp_data.baud_error))
      else $error("baud result both valid and in error");

   // The smallest possible rate is well above zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.baud_valid) |-> (rsp_data.baud_rate != '0))
      else $error("divider produced a zero baud rate");

endmodule

@@ tb/sv/serial_bridge_vendor_request_decoder_tb.sv @@
`timescale 1ns / 1ps

module serial_bridge_vendor_request_decoder_tb;
   import sbvrd_pkg::*;

   localparam logic [31:0] BaudTop       = 32'd1532620800;
   localparam logic [31:0] BaudSpan      = 32'h10000;
   localparam logic [7:0]  DivisorTop    = 8'd3;
   localparam logic [7:0]  CodeUnusedLow = 8'h00;
   localparam logic [7:0]  CodeUnusedTop = 8'hFF;
   localparam logic [15:0] WordUnused    = 16'h0000;
   localparam logic [1:0]  CsrUnused     = 2'd3;
   localparam int          WatchdogLimit = 4000;
   localparam int          PhaseItems    = 205;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   bit      no_idling = 1'b0;
   bit      reply_fire;
   rsp_type reply_seen;
   int      stall_left = 0;
   bit      moved;
   int      quiet_cycles = 0;

   class reply_ledger;
      logic [15:0] version_word;
      logic [15:0] attach_word;
      logic [15:0] status_word;
      rsp_type     awaited_replies[$];
      int          mismatch_count;

      function new();
         version_word   = VersionReset;
         attach_word    = AttachReset;
         status_word    = StatusReset;
         mismatch_count = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [15:0] value);
         case (index)
            CsrVersion: version_word = value;
            CsrAttach:  attach_word  = value;
            CsrStatus:  status_word  = value;
            default: ;
         endcase
      endfunction

      function rsp_type decode_request(req_type r);
         rsp_type     o;
         logic [7:0]  factor;
         logic [7:0]  divisor;
         logic [7:0]  mode;
         logic [31:0] span;
         int          shift;
         o        = '0;
         o.status = 1'b1;
         factor   = r.index_word[15:8];
         divisor  = r.index_word[7:0];
         mode     = r.index_word[7:0];
         case (r.func)
            ReqVersion: begin
               o.status          = 1'b0;
               o.response_length = 2'd2;
               o.response_word   = version_word;
            end
            ReqRead: begin
               if (r.value_word == RegAttach) begin
                  o.status          = 1'b0;
                  o.response_length = 2'd2;
                  o.response_word   = attach_word;
               end else if (r.value_word == RegStatus) begin
                  o.status          = 1'b0;
                  o.response_length = 2'd2;
                  o.response_word   = status_word;
               end
            end
            ReqWrite: begin
               o.status = 1'b0;
               if (r.value_word == CmdBaud) begin
                  if (divisor > DivisorTop) begin
                     o.baud_error = 1'b1;
                  end else begin
                     shift       = 3 * (int'(DivisorTop) - int'(divisor));
                     span        = (BaudSpan - {16'd0, factor, 8'd0}) << shift;
                     o.baud_rate  = 23'(BaudTop / span);
                     o.baud_valid = 1'b1;
                  end
               end else if (r.value_word == CmdMode) begin
                  o.mode_valid = 1'b1;
                  o.data_bits  = {2'b00, mode[1:0]} + 4'd5;
                  o.stop_bits  = {1'b0, mode[2]} + 2'd1;
                  // The stick bit only means something once parity is enabled.
                  if (mode[3]) begin
                     o.parity_kind  = mode[4] ? 2'd2 : 2'd1;
                     o.parity_stick = mode[5];
                  end
               end
            end
            ReqInit, ReqModem: o.status = 1'b0;
            default: ;
         endcase
         return o;
      endfunction

      function void note_request(req_type r);
         awaited_replies.push_back(decode_request(r));
      endfunction

      function int outstanding();
         return awaited_replies.size();
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (awaited_replies.size() == 0) begin
            $display("%0t: reply word expected none actual %h", $time, got);
            mismatch_count++;
            return;
         end
         want = awaited_replies.pop_front();
         compare("status", 32'(want.status), 32'(got.status));
         compare("response_length", 32'(want.response_length),
                 32'(got.response_length));
         compare("response_word", 32'(want.response_word), 32'(got.response_word));
         compare("baud_valid", 32'(want.baud_valid), 32'(got.baud_valid));
         compare("baud_error", 32'(want.baud_error), 32'(got.baud_error));
         compare("baud_rate", 32'(want.baud_rate), 32'(got.baud_rate));
         compare("mode_valid", 32'(want.mode_valid), 32'(got.mode_valid));
         compare("data_bits", 32'(want.data_bits), 32'(got.data_bits));
         compare("stop_bits", 32'(want.stop_bits), 32'(got.stop_bits));
         compare("parity_kind", 32'(want.parity_kind), 32'(got.parity_kind));
         compare("parity_stick", 32'(want.parity_stick), 32'(got.parity_stick));
      endfunction
   endclass

   reply_ledger ledger;

   serial_bridge_vendor_request_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Handshakes are sampled at the falling edge, where everything driven at the
   // previous rising edge has settled, and take effect at the next rising edge.
   always begin
      @(negedge clock);
      reply_fire = rsp_valid && !rsp_stall;
      reply_seen = rsp_data;
      @(posedge clock);
      if (reply_fire) begin
         ledger.check_reply(reply_seen);
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (!no_idling && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 17);
      end
      rsp_stall <= (stall_left > 0);
   end

   initial begin : watchdog
      while (quiet_cycles < WatchdogLimit) begin
         @(negedge clock);
         moved = (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                 || (csr_valid && csr_ready);
         @(posedge clock);
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
      $display("[serial_bridge_vendor_request_decoder] ERROR");
      $finish;
   end

   // Valid stays high after an accept; settle() lowers it.
   task automatic send_request(input req_type r);
      bit took;
      if (!no_idling && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      ledger.note_request(r);
   endtask

   task automatic issue(input logic [7:0] code, input logic [15:0] value,
                        input logic [15:0] index);
      req_type r;
      r.func       = code;
      r.value_word = value;
      r.index_word = index;
      send_request(r);
   endtask

   // Every request yields a reply, so the block is idle once none is awaited.
   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] value,
                                 input bit last);
      bit took;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      ledger.set_register(index, value);
      if (last) begin
         csr_valid <= 1'b0;
      end
   endtask

   task automatic program_registers(input logic [15:0] version, input logic [15:0] attach,
                                    input logic [15:0] status);
      write_register(CsrUnused, 16'($urandom), 1'b0);
      write_register(CsrVersion, version, 1'b0);
      write_register(CsrAttach, attach, 1'b0);
      write_register(CsrStatus, status, 1'b1);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly well-formed requests with random content, the rest arbitrary codes.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.func       = 8'($urandom);
      r.value_word = 16'($urandom);
      r.index_word = 16'($urandom);
      pick         = $urandom_range(0, 99);
      if (pick < 10) begin
         r.func = ReqVersion;
      end else if (pick < 30) begin
         r.func = ReqRead;
         case ($urandom_range(0, 2))
            0:       r.value_word = RegAttach;
            1:       r.value_word = RegStatus;
            default: ;
         endcase
      end else if (pick < 55) begin
         r.func       = ReqWrite;
         r.value_word = CmdBaud;
         if ($urandom_range(0, 4) != 0) begin
            r.index_word[7:0] = 8'($urandom_range(0, 3));
         end
      end else if (pick < 70) begin
         r.func       = ReqWrite;
         r.value_word = CmdMode;
      end else if (pick < 75) begin
         r.func = ReqWrite;
      end else if (pick < 85) begin
         r.func = $urandom_range(0, 1) ? ReqInit : ReqModem;
      end
      return r;
   endfunction

   initial begin : stimulus
      int phase;
      int count;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      ledger    = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Register reset values, baud extremes, divisor errors, line modes and unknown requests.
      issue(ReqVersion, 16'h0000, 16'h0000);
      issue(ReqVersion, 16'hFFFF, 16'hFFFF);
      issue(ReqRead, RegAttach, 16'h0000);
      issue(ReqRead, RegStatus, 16'hFFFF);
      issue(ReqRead, WordUnused, 16'h0000);
      issue(ReqRead, 16'hFFFF, 16'h1234);
      issue(ReqWrite, CmdBaud, 16'h0000);
      issue(ReqWrite, CmdBaud, 16'hFF03);
      issue(ReqWrite, CmdBaud, 16'h8001);
      issue(ReqWrite, CmdBaud, 16'hFF02);
      issue(ReqWrite, CmdBaud, 16'h0004);
      issue(ReqWrite, CmdBaud, 16'hFFFF);
      issue(ReqWrite, CmdMode, 16'h0000);
      issue(ReqWrite, CmdMode, 16'hFF3F);
      issue(ReqWrite, CmdMode, 16'h000B);
      issue(ReqWrite, CmdMode, 16'h0027);
      issue(ReqWrite, WordUnused, 16'hFFFF);
      issue(ReqInit, 16'h0000, 16'h0000);
      issue(ReqModem, 16'hFFFF, 16'hFFFF);
      issue(CodeUnusedLow, RegAttach, 16'h0000);
      issue(CodeUnusedTop, CmdBaud, 16'h0003);

      settle();
      program_registers(16'h0000, 16'hFFFF, 16'hA55A);
      issue(ReqVersion, 16'h0000, 16'h0000);
      issue(ReqRead, RegAttach, 16'h0000);
      issue(ReqRead, RegStatus, 16'h0000);
      settle();
      program_registers(16'hFFFF, 16'h0000, 16'h0000);
      issue(ReqVersion, 16'h0000, 16'h0000);
      issue(ReqRead, RegAttach, 16'h0000);
      issue(ReqRead, RegStatus, 16'h0000);

      for (phase = 0; phase < 5; phase++) begin
         settle();
         program_registers(pick_word(), pick_word(), pick_word());
         if (phase == 4) begin
            no_idling = 1'b1;
         end
         for (count = 0; count < PhaseItems; count++) begin
            send_request(random_request());
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (ledger.mismatch_count == 0 && ledger.outstanding() == 0) begin
         $display("[serial_bridge_vendor_request_decoder] OK");
      end else begin
         $display("[serial_bridge_vendor_request_decoder] ERROR");
      end
      $finish;
   end

endmodule
